// ===== rtl/cmbf_pkg.sv =====
// cmbf_pkg: shared types and constants of the character-to-bit-frame unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps
`default_nettype none

package cmbf_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIFF_W  = 7;
    localparam int LEN_W   = 10;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARKER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAD    = 2'd2;

    localparam logic [1:0] REG_REFERENCE_CHAR = 2'd0;
    localparam logic [1:0] REG_BLOCK_FORMAT   = 2'd1;
    localparam logic [1:0] REG_ADD_MARKERS    = 2'd2;
    localparam logic [1:0] REG_SECTOR_LENGTH  = 2'd3;

    localparam logic [LEN_W-1:0] SECTOR_LENGTH_RESET = 10'd10;

    // last bit index of a character, plain and block format
    localparam logic [IDX_W-1:0] LAST_IDX_PLAIN = 4'd6;
    localparam logic [IDX_W-1:0] LAST_IDX_BLOCK = 4'd9;
    localparam logic [IDX_W-1:0] CHAR_BITS      = 4'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] reference_char;
        logic              block_format;
        logic              add_markers;
        logic [LEN_W-1:0]  sector_length;
    } cfg_t;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              wide;
        logic              marks;
        logic              last;
    } entry_t;

    typedef enum logic [1:0] {
        BK_BITS,
        BK_PAD,
        BK_END
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/cmbf_in_if.sv =====
// cmbf_in_if: input channel, one message character per word
// depends on no other file
`timescale 1ns / 1ps
`default_nettype none

interface cmbf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_message;

    modport source (output valid, output character, output end_of_message, input ready);
    modport sink (input valid, input character, input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmbf_out_if.sv =====
// cmbf_out_if: output channel, one frame result per word
// depends on no other file
`timescale 1ns / 1ps
`default_nettype none

interface cmbf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic       data_bit;
    logic [9:0] pad_count;
    logic       frame_last;

    modport source (output valid, output out_kind, output data_bit, output pad_count,
                    output frame_last, input ready);
    modport sink (input valid, input out_kind, input data_bit, input pad_count,
                  input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmbf_cfg_regs.sv =====
// cmbf_cfg_regs: apb-style configuration register file
// depends on cmbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmbf_cfg_regs
    import cmbf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready,
    output      cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_REFERENCE_CHAR: cfg_next.reference_char = pwdata[CHAR_W-1:0];
                REG_BLOCK_FORMAT:   cfg_next.block_format   = pwdata[0];
                REG_ADD_MARKERS:    cfg_next.add_markers    = pwdata[0];
                REG_SECTOR_LENGTH:  cfg_next.sector_length  = pwdata[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_char <= '0;
            cfg_reg.block_format   <= 1'b0;
            cfg_reg.add_markers    <= 1'b0;
            cfg_reg.sector_length  <= SECTOR_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_REFERENCE_CHAR: prdata = DATA_W'(cfg_reg.reference_char);
            REG_BLOCK_FORMAT:   prdata = DATA_W'(cfg_reg.block_format);
            REG_ADD_MARKERS:    prdata = DATA_W'(cfg_reg.add_markers);
            REG_SECTOR_LENGTH:  prdata = DATA_W'(cfg_reg.sector_length);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cmbf_front.sv =====
// cmbf_front: accepts characters, forms the 7-bit code and queues the words
// depends on cmbf_pkg and cmbf_in_if
`timescale 1ns / 1ps
`default_nettype none

module cmbf_front
    import cmbf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    cmbf_in_if.sink     msg,
    output      logic   head_valid,
    output      entry_t head,
    input  wire logic   pop
);

    entry_t     q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    entry_t     new_entry;
    logic [CHAR_W-1:0] diff_full;

    assign msg.ready  = (count_reg != 2'd2);
    assign push       = msg.valid && msg.ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_mem_reg[rd_ptr_reg];

    // classify: code, bit count and marker mode travel with the word
    always_comb
    begin
        diff_full       = msg.character - cfg.reference_char;
        new_entry.diff  = diff_full[DIFF_W-1:0];
        new_entry.wide  = cfg.block_format;
        new_entry.marks = cfg.add_markers;
        new_entry.last  = msg.end_of_message;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cmbf_back.sv =====
// cmbf_back: sector sequencer, emits data bits, markers and pad runs
// depends on cmbf_pkg and cmbf_out_if
`timescale 1ns / 1ps
`default_nettype none

module cmbf_back
    import cmbf_pkg::*;
#(
    parameter int SECTOR_COUNT_WIDTH = 10
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   head_valid,
    input  wire entry_t head,
    output      logic   pop,
    cmbf_out_if.source  frame
);

    localparam int PW = SECTOR_COUNT_WIDTH;
    localparam int CW = (SECTOR_COUNT_WIDTH > LEN_W) ? SECTOR_COUNT_WIDTH : LEN_W;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              mk_done_reg;
    logic              mk_done_next;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              bit_reg;
    logic [LEN_W-1:0]  pad_reg;
    logic              last_reg;

    logic              advance;
    logic              work;
    logic              emit;
    logic              marker_step;
    logic              end_of_char;
    logic [LEN_W-1:0]  len_eff;
    logic [CW-1:0]     len_x;
    logic [CW-1:0]     pos_x;
    logic [PW-1:0]     pos_eff;
    logic [PW-1:0]     pos_inc;
    logic [PW-1:0]     pos_adv;
    logic [CW-1:0]     pad_x;
    logic [IDX_W-1:0]  last_idx;
    logic              bit_val;

    logic [KIND_W-1:0] res_kind;
    logic              res_bit;
    logic [LEN_W-1:0]  res_pad;
    logic              res_last;

    assign frame.valid      = out_valid_reg;
    assign frame.out_kind   = kind_reg;
    assign frame.data_bit   = bit_reg;
    assign frame.pad_count  = pad_reg;
    assign frame.frame_last = last_reg;

    assign advance = !out_valid_reg || frame.ready;
    assign work    = (state_reg != BK_BITS) || head_valid;
    assign emit    = advance && work;

    // sector arithmetic
    always_comb
    begin
        len_eff     = (cfg.sector_length == '0) ? LEN_W'(1) : cfg.sector_length;
        len_x       = CW'(len_eff);
        pos_x       = CW'(pos_reg);
        pos_eff     = (pos_x >= len_x) ? '0 : pos_reg;
        pos_inc     = pos_eff + PW'(1);
        pos_adv     = (CW'(pos_inc) >= len_x) ? '0 : pos_inc;
        pad_x       = len_x - pos_x;
        last_idx    = head.wide ? LAST_IDX_BLOCK : LAST_IDX_PLAIN;
        end_of_char = (idx_reg == last_idx);
        marker_step = head.marks && (pos_eff == '0) && !mk_done_reg;
        bit_val     = (idx_reg < CHAR_BITS) ?
                      head.diff[3'(LAST_IDX_PLAIN - idx_reg)] : 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_BITS:
            begin
                if (emit && !marker_step && end_of_char && head.last && head.marks)
                    state_next = (pos_adv != '0) ? BK_PAD : BK_END;
            end
            BK_PAD:
            begin
                if (emit)
                    state_next = BK_END;
            end
            BK_END:
            begin
                if (emit)
                    state_next = BK_BITS;
            end
            default: state_next = BK_BITS;
        endcase
    end

    always_comb
    begin
        res_kind     = KIND_DATA;
        res_bit      = 1'b0;
        res_pad      = '0;
        res_last     = 1'b0;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        mk_done_next = mk_done_reg;
        pop          = 1'b0;
        unique case (state_reg)
            BK_BITS:
            begin
                if (marker_step)
                begin
                    res_kind     = KIND_MARKER;
                    pos_next     = pos_eff;
                    mk_done_next = 1'b1;
                end
                else
                begin
                    res_bit      = bit_val;
                    mk_done_next = 1'b0;
                    if (head.marks)
                        pos_next = pos_adv;
                    if (end_of_char)
                    begin
                        idx_next = '0;
                        pop      = emit;
                        if (head.last && !head.marks)
                        begin
                            res_last = 1'b1;
                            pos_next = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            BK_PAD:
            begin
                res_kind = KIND_PAD;
                res_pad  = pad_x[LEN_W-1:0];
            end
            BK_END:
            begin
                res_kind = KIND_MARKER;
                res_last = 1'b1;
                pos_next = '0;
            end
            default: res_kind = KIND_DATA;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_BITS;
            pos_reg       <= '0;
            idx_reg       <= '0;
            mk_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= work;
            if (emit)
            begin
                state_reg   <= state_next;
                pos_reg     <= pos_next;
                idx_reg     <= idx_next;
                mk_done_reg <= mk_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= res_kind;
            bit_reg  <= res_bit;
            pad_reg  <= res_pad;
            last_reg <= res_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/char_to_marked_bit_frame_unit.sv =====
// Converts a message, one character per input word, into a bit frame of one result word per
// cycle while not stalled: seven data bits of the character minus reference_char (msb first),
// three zero bits in block format, and with markers on a start marker before each sector, an
// end marker, and a closing pad run before it when the last sector is not full. Each character
// gives 7 or 10 data bits plus one result per marker, and with markers on 1 or 2 more at the
// end of a message. A two-word queue lets the next characters be accepted meanwhile.
// depends on cmbf_pkg, cmbf_in_if, cmbf_out_if, cmbf_cfg_regs, cmbf_front, cmbf_back
`timescale 1ns / 1ps
`default_nettype none

module char_to_marked_bit_frame_unit
    import cmbf_pkg::*;
#(
    parameter int SECTOR_COUNT_WIDTH = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    cmbf_in_if.sink                msg,
    cmbf_out_if.source             frame,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready
);

    cfg_t   cfg;
    logic   head_valid;
    entry_t head;
    logic   pop;

    cmbf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cmbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .msg        (msg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    cmbf_back #(
        .SECTOR_COUNT_WIDTH (SECTOR_COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .frame      (frame)
    );

endmodule

`default_nettype wire

// ===== rtl/cmbf_checker.sv =====
// cmbf_checker: port-level checks of the frame output, bound to the top level
// depends on cmbf_pkg and char_to_marked_bit_frame_unit
`timescale 1ns / 1ps
`default_nettype none

module cmbf_checker
    import cmbf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [KIND_W-1:0] out_kind,
    input wire logic              data_bit,
    input wire logic [LEN_W-1:0]  pad_count,
    input wire logic              frame_last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(data_bit)
            && $stable(pad_count) && $stable(frame_last))
        else $error("result word changed while stalled");

    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_PAD) |-> (pad_count != '0) && !data_bit && !frame_last)
        else $error("bad pad run word");

    a_marker_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_MARKER) |-> (pad_count == '0) && !data_bit)
        else $error("marker word carries payload");

endmodule

bind char_to_marked_bit_frame_unit cmbf_checker u_cmbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .out_kind   (frame.out_kind),
    .data_bit   (frame.data_bit),
    .pad_count  (frame.pad_count),
    .frame_last (frame.frame_last)
);

`default_nettype wire
